@@ rtl/jfp_pkg.sv @@
// Shared types and constants for the Jacobi four-point sweep core.
package jfp_pkg;

    // Width of the row and column tags on the result channel
    localparam int OUT_IDX_W = 5;

    // Per-item classification passed from the front end to the back end
    typedef struct packed {
        logic                 emit_interior;  // interior cell above is finished
        logic                 emit_boundary;  // the arriving cell is a boundary cell
        logic                 frame_end;      // arriving cell is the last of the frame
        logic [OUT_IDX_W-1:0] row;            // row of the arriving cell
        logic [OUT_IDX_W-1:0] col;            // column of the arriving cell
    } jfp_tag_t;

    localparam int TAG_W = $bits(jfp_tag_t);

endpackage

@@ rtl/jfp_in_if.sv @@
// Input stream channel: one grid cell value per transfer.
interface jfp_in_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

@@ rtl/jfp_out_if.sv @@
// Result stream channel: one updated cell with its position and frame status per transfer.
interface jfp_out_if #(
    parameter int VALUE_WIDTH = 16
);
    import jfp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_IDX_W-1:0]   cell_row;
    logic [OUT_IDX_W-1:0]   cell_col;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] max_increase;
    logic                   run_last;
    logic                   frame_done;

    modport source (
        output valid, output cell_row, output cell_col, output new_value,
        output max_increase, output run_last, output frame_done, input ready
    );
    modport sink (
        input valid, input cell_row, input cell_col, input new_value,
        input max_increase, input run_last, input frame_done, output ready
    );
endinterface

@@ rtl/jfp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module jfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/jfp_front.sv @@
// Front end: raster counters, line stores, stencil sum and result classification.
module jfp_front #(
    parameter int GRID_SIDE   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    jfp_in_if.sink                 in_ch,
    output logic                   push_valid,
    input  logic                   push_ready,
    output jfp_pkg::jfp_tag_t      push_tag,
    output logic [VALUE_WIDTH-1:0] push_old,
    output logic [VALUE_WIDTH-1:0] push_new,
    output logic [VALUE_WIDTH-1:0] push_inc
);
    import jfp_pkg::*;

    localparam int IDX_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int SUM_W = VALUE_WIDTH + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIDE - 1);

    // Raster position of the next cell
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;

    // Compute stage holding one accepted cell
    logic                   s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]       s1_row_reg;
    logic [IDX_W-1:0]       s1_col_reg;
    logic [VALUE_WIDTH-1:0] s1_value_reg;

    // Sliding window over the row above: (r-1,c) and (r-1,c-1)
    logic [VALUE_WIDTH-1:0] above_reg;
    logic [VALUE_WIDTH-1:0] left_reg;

    logic [VALUE_WIDTH-1:0] rd_right;   // (r-1,c+1) from line store A
    logic [VALUE_WIDTH-1:0] rd_up2;     // (r-2,c) from line store B
    logic [IDX_W-1:0]       right_addr;

    logic                   accept;
    logic                   s1_fire;
    logic                   is_interior;
    logic                   is_boundary;
    logic                   is_frame_end;
    logic [SUM_W-1:0]       stencil_sum;
    logic [VALUE_WIDTH-1:0] relaxed;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_fire;

    // Classification of the cell in the compute stage
    assign is_interior  = (s1_row_reg >= IDX_W'(2)) && (s1_col_reg != '0)
                          && (s1_col_reg != LAST_IDX);
    assign is_boundary  = (s1_row_reg == '0) || (s1_row_reg == LAST_IDX)
                          || (s1_col_reg == '0) || (s1_col_reg == LAST_IDX);
    assign is_frame_end = (s1_row_reg == LAST_IDX) && (s1_col_reg == LAST_IDX);

    assign push_valid = s1_valid_reg && (is_interior || is_boundary);
    assign s1_fire    = s1_valid_reg && (!(is_interior || is_boundary) || push_ready);

    // Four-point average of the cell above, truncated
    assign stencil_sum = SUM_W'(left_reg) + SUM_W'(rd_right)
                       + SUM_W'(rd_up2) + SUM_W'(s1_value_reg);
    assign relaxed     = stencil_sum[SUM_W-1:2];

    assign push_tag.emit_interior = is_interior;
    assign push_tag.emit_boundary = is_boundary;
    assign push_tag.frame_end     = is_frame_end;
    assign push_tag.row           = OUT_IDX_W'(s1_row_reg);
    assign push_tag.col           = OUT_IDX_W'(s1_col_reg);
    assign push_old               = s1_value_reg;
    assign push_new               = relaxed;
    assign push_inc               = (relaxed > above_reg) ? (relaxed - above_reg) : '0;

    // Line store A reads one column ahead; wraps to column 0 at the row end
    assign right_addr = (col_reg == LAST_IDX) ? '0 : (col_reg + IDX_W'(1));

    // Line store A: row r-1, written by arriving cells
    jfp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (GRID_SIDE)
    ) u_line_a (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (in_ch.cell_value),
        .re    (accept),
        .raddr (right_addr),
        .rdata (rd_right)
    );

    // Line store B: row r-2, fed from the window as cells leave the compute stage
    jfp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (GRID_SIDE)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (above_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_up2)
    );

    // Next position and stage occupancy
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (col_reg == LAST_IDX)
            begin
                col_next = '0;
                row_next = (row_reg == LAST_IDX) ? '0 : (row_reg + IDX_W'(1));
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage payload and window registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_value_reg <= in_ch.cell_value;
        end
        if (s1_fire)
        begin
            above_reg <= rd_right;
            left_reg  <= above_reg;
        end
    end
endmodule

@@ rtl/jfp_queue.sv @@
// Small register FIFO decoupling the front end from the back end.
module jfp_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              head_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

@@ rtl/jfp_back.sv @@
// Back end: splits each queued item into its results, tracks the frame's largest increase.
module jfp_back #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  jfp_pkg::jfp_tag_t      head_tag,
    input  logic [VALUE_WIDTH-1:0] head_old,
    input  logic [VALUE_WIDTH-1:0] head_new,
    input  logic [VALUE_WIDTH-1:0] head_inc,
    output logic                   pop,
    jfp_out_if.source              out_ch
);
    import jfp_pkg::*;

    logic                   phase_reg, phase_next;       // interior part already sent
    logic [VALUE_WIDTH-1:0] run_max_reg, run_max_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]   row_reg, row_next;
    logic [OUT_IDX_W-1:0]   col_reg, col_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] max_reg, max_next;
    logic                   last_reg, last_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] raised_max;
    logic                   load;

    assign load       = head_valid && (!out_valid_reg || out_ch.ready);
    assign raised_max = (head_inc > run_max_reg) ? head_inc : run_max_reg;

    // Result selection and maximum tracking
    always_comb
    begin
        phase_next     = phase_reg;
        run_max_next   = run_max_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        row_next       = row_reg;
        col_next       = col_reg;
        value_next     = value_reg;
        max_next       = max_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            priority if (head_tag.emit_interior && !phase_reg)
            begin
                // relaxed cell one row above the arriving cell
                row_next     = head_tag.row - OUT_IDX_W'(1);
                col_next     = head_tag.col;
                value_next   = head_new;
                max_next     = raised_max;
                run_max_next = raised_max;
                last_next    = !head_tag.emit_boundary;
                done_next    = 1'b0;
                if (head_tag.emit_boundary)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                // boundary cell passes through
                row_next   = head_tag.row;
                col_next   = head_tag.col;
                value_next = head_old;
                max_next   = run_max_reg;
                last_next  = 1'b1;
                done_next  = head_tag.frame_end;
                phase_next = 1'b0;
                pop        = 1'b1;
                if (head_tag.frame_end)
                begin
                    run_max_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_max_reg   <= run_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        max_reg   <= max_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.cell_row     = row_reg;
    assign out_ch.cell_col     = col_reg;
    assign out_ch.new_value    = value_reg;
    assign out_ch.max_increase = max_reg;
    assign out_ch.run_last     = last_reg;
    assign out_ch.frame_done   = done_reg;
endmodule

@@ rtl/jacobi_four_point_sweep_core.sv @@
// Streaming Jacobi relaxation core, four-point Laplace stencil over a square grid.
//
// in_ch carries one Q8.8 cell value per transfer in raster order, column 0 first.
// out_ch carries results tagged with row and column. Boundary cells come out as they
// arrive; interior cell (r,c) comes out once cell (r+1,c) has been taken in. A cell in
// the last row gives up to two results: the relaxed cell above it, then itself.
// max_increase is the largest positive new-minus-old so far in the frame; frame_done
// marks the result for the last grid cell, after which the maximum restarts at zero.
// Throughput: one cell per clock while the queue has room. The output register sends one
// result per clock while out_ch is ready, so a two-result cell holds the queue head for
// both; the four-entry queue between the front and back ends absorbs short runs of these,
// and along the last row in_ch slows down once the queue is full. A result is registered
// in the compute stage with the line store reads, then in a queue entry, then in the
// output register before it shows on out_ch. Reset clears the raster position, queue,
// output valid and maximum; the line stores are not cleared, since unwritten entries
// are read only for cells whose results do not use them. While out_ch stalls the output
// register holds; in_ch keeps taking cells until the queue and the compute stage are
// full, then its ready drops.
module jacobi_four_point_sweep_core #(
    parameter int GRID_SIDE   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    jfp_in_if.sink    in_ch,
    jfp_out_if.source out_ch
);
    import jfp_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_DATA_W    = TAG_W + 3 * VALUE_WIDTH;

    logic                   push_valid;
    logic                   push_ready;
    jfp_tag_t               push_tag;
    logic [VALUE_WIDTH-1:0] push_old;
    logic [VALUE_WIDTH-1:0] push_new;
    logic [VALUE_WIDTH-1:0] push_inc;
    logic [Q_DATA_W-1:0]    push_data;
    logic                   head_valid;
    logic                   pop;
    logic [Q_DATA_W-1:0]    head_data;
    jfp_tag_t               head_tag;
    logic [VALUE_WIDTH-1:0] head_old;
    logic [VALUE_WIDTH-1:0] head_new;
    logic [VALUE_WIDTH-1:0] head_inc;

    jfp_front #(
        .GRID_SIDE   (GRID_SIDE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tag   (push_tag),
        .push_old   (push_old),
        .push_new   (push_new),
        .push_inc   (push_inc)
    );

    // Queue entry packing: tag, old value, relaxed value, increase
    assign push_data = {push_tag, push_old, push_new, push_inc};
    assign head_tag  = jfp_tag_t'(head_data[Q_DATA_W-1 -: TAG_W]);
    assign head_old  = head_data[3*VALUE_WIDTH-1 -: VALUE_WIDTH];
    assign head_new  = head_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
    assign head_inc  = head_data[VALUE_WIDTH-1:0];

    jfp_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    jfp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_tag   (head_tag),
        .head_old   (head_old),
        .head_new   (head_new),
        .head_inc   (head_inc),
        .pop        (pop),
        .out_ch     (out_ch)
    );
endmodule

@@ rtl/jfp_checker.sv @@
// Port-level checks on the result channel of the sweep core, bound to the top level.
module jfp_checker #(
    parameter int GRID_SIDE   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [jfp_pkg::OUT_IDX_W-1:0] cell_row,
    input logic [jfp_pkg::OUT_IDX_W-1:0] cell_col,
    input logic [VALUE_WIDTH-1:0]        new_value,
    input logic [VALUE_WIDTH-1:0]        max_increase,
    input logic                          run_last,
    input logic                          frame_done
);
    import jfp_pkg::*;

    localparam logic [OUT_IDX_W-1:0] LAST_TAG = OUT_IDX_W'(GRID_SIDE - 1);

    // A stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_row) && $stable(cell_col)
            && $stable(new_value) && $stable(max_increase) && $stable(run_last)
            && $stable(frame_done))
    else $error("result changed while stalled");

    // End of frame is always the last result of its cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

    // End of frame belongs to the bottom-right corner
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> (cell_row == LAST_TAG) && (cell_col == LAST_TAG))
    else $error("frame_done away from the last cell");

    // Nothing is offered straight out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind jacobi_four_point_sweep_core jfp_checker #(
    .GRID_SIDE   (GRID_SIDE),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_jfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cell_row     (out_ch.cell_row),
    .cell_col     (out_ch.cell_col),
    .new_value    (out_ch.new_value),
    .max_increase (out_ch.max_increase),
    .run_last     (out_ch.run_last),
    .frame_done   (out_ch.frame_done)
);
